FILE: design/asc_pkg.sv
package asc_pkg;

    localparam int NUM_WIDTH_DEF = 16;
    localparam int LIMIT_W       = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;
    localparam int COUNT_W       = 8;
    localparam int SUM_W         = 18;

    typedef struct packed {
        logic load;
        logic init_pass;
        logic div_start;
        logic accumulate;
        logic save_first;
        logic out_load;
        logic amic_check;
    } cmd_t;

    typedef struct packed {
        logic loop_end;
        logic div_done;
        logic div_busy;
        logic amic_try;
        logic out_free;
    } sts_t;

endpackage

FILE: design/asc_in_if.sv
interface asc_in_if #(
    parameter int NUM_WIDTH = asc_pkg::NUM_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [NUM_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

FILE: design/asc_out_if.sv
interface asc_out_if;
    logic                          valid;
    logic                          ready;
    logic [asc_pkg::COUNT_W-1:0]   divisor_count;
    logic [asc_pkg::SUM_W-1:0]     divisor_sum;
    logic                          is_perfect;
    logic                          is_amicable;

    modport source (output valid, output divisor_count, output divisor_sum,
                    output is_perfect, output is_amicable, input ready);
    modport sink   (input valid, input divisor_count, input divisor_sum,
                    input is_perfect, input is_amicable, output ready);
endinterface

FILE: design/aliquot_sum_classifier.sv
// Channel  Dir  Payload                                                Handshake
// in_ch    in   number                                                 valid/ready
// out_ch   out  divisor_count, divisor_sum, is_perfect, is_amicable    valid/ready
// cfg      in   cfg_wdata (upper_limit)                                cfg_we
//
// One request at a time. W = max(NUM_WIDTH, 16). A pass over a value m tries each
// divisor d from 1 up to floor(sqrt(m)) with the bit-serial divider (one quotient
// bit per cycle); a request takes one pass over n, plus one over its divisor sum
// when the amicable test applies, besides accepting and loading the request.
// Reset restores upper_limit to 65535 and empties the output register.
// A waiting result does not stall the next request: in_ch is ready whenever
// the engine is free, and only the final result load waits for out_ch.
module aliquot_sum_classifier #(
    parameter int NUM_WIDTH = asc_pkg::NUM_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [asc_pkg::LIMIT_W-1:0] cfg_wdata,
    asc_in_if.sink                      in_ch,
    asc_out_if.source                   out_ch
);

    asc_pkg::cmd_t cmd;
    asc_pkg::sts_t sts;

    asc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    asc_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_number    (in_ch.number),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_count    (out_ch.divisor_count),
        .out_sum      (out_ch.divisor_sum),
        .out_perfect  (out_ch.is_perfect),
        .out_amicable (out_ch.is_amicable)
    );

endmodule

FILE: design/asc_div.sv
module asc_div #(
    parameter int OP_W = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] dividend,
    input  logic [OP_W-1:0] divisor,
    output logic [OP_W-1:0] quotient,
    output logic [OP_W-1:0] remainder,
    output logic            busy,
    output logic            done
);

    localparam int STEP_W = $clog2(OP_W);

    logic [OP_W-1:0]   rem_reg, rem_next;
    logic [OP_W-1:0]   quo_reg, quo_next;
    logic [OP_W-1:0]   dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [OP_W:0]     shifted;
    logic [OP_W:0]     diff;

    assign shifted = {rem_reg, quo_reg[OP_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[OP_W])
            begin
                rem_next = diff[OP_W-1:0];
                quo_next = {quo_reg[OP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[OP_W-1:0];
                quo_next = {quo_reg[OP_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(OP_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;

endmodule

FILE: design/asc_datapath.sv
module asc_datapath #(
    parameter int NUM_WIDTH = asc_pkg::NUM_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [asc_pkg::LIMIT_W-1:0] cfg_wdata,
    input  logic [NUM_WIDTH-1:0]        in_number,
    input  asc_pkg::cmd_t               cmd,
    output asc_pkg::sts_t               sts,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [asc_pkg::COUNT_W-1:0] out_count,
    output logic [asc_pkg::SUM_W-1:0]   out_sum,
    output logic                        out_perfect,
    output logic                        out_amicable
);

    localparam int OP_W  = (NUM_WIDTH > asc_pkg::LIMIT_W) ? NUM_WIDTH : asc_pkg::LIMIT_W;
    localparam int SQ_W  = OP_W + 1;
    localparam int ACC_W = OP_W + 3;

    logic [asc_pkg::LIMIT_W-1:0] limit_reg;
    logic [OP_W-1:0]             n_reg, m_reg, d_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic [ACC_W-1:0]            sum_reg, s1_reg;
    logic [OP_W-1:0]             cnt_reg, c1_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [asc_pkg::COUNT_W-1:0] count_reg;
    logic [asc_pkg::SUM_W-1:0]   osum_reg;
    logic                        perfect_reg, amicable_reg;

    logic [OP_W-1:0]  div_q, div_r;
    logic             div_busy, div_done;
    logic             hit_low, hit_high;
    logic [ACC_W-1:0] add_low, add_high;

    asc_div #(
        .OP_W (OP_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (m_reg),
        .divisor   (d_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .busy      (div_busy),
        .done      (div_done)
    );

    assign hit_low  = (div_r == '0);
    assign hit_high = hit_low && (div_q != d_reg) && (div_q != m_reg);
    assign add_low  = hit_low  ? ACC_W'(d_reg) : '0;
    assign add_high = hit_high ? ACC_W'(div_q) : '0;

    assign sts.loop_end = (SQ_W'(m_reg) < sq_reg) || (m_reg < OP_W'(2));
    assign sts.div_done = div_done;
    assign sts.div_busy = div_busy;
    assign sts.amic_try = (ACC_W'(n_reg) < sum_reg) && (sum_reg <= ACC_W'(limit_reg));
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= asc_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= OP_W'(in_number);
            m_reg <= OP_W'(in_number);
        end
        if (cmd.init_pass)
        begin
            d_reg   <= OP_W'(1);
            sq_reg  <= SQ_W'(1);
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.accumulate)
        begin
            sum_reg <= sum_reg + add_low + add_high;
            cnt_reg <= cnt_reg + OP_W'(hit_low) + OP_W'(hit_high);
            d_reg   <= d_reg + OP_W'(1);
            sq_reg  <= sq_reg + {d_reg, 1'b1};
        end
        if (cmd.save_first)
        begin
            s1_reg <= sum_reg;
            c1_reg <= cnt_reg;
            m_reg  <= sum_reg[OP_W-1:0];
        end
        if (cmd.out_load)
        begin
            count_reg    <= (|c1_reg[OP_W-1:asc_pkg::COUNT_W]) ? '1
                                                              : c1_reg[asc_pkg::COUNT_W-1:0];
            osum_reg     <= (|s1_reg[ACC_W-1:asc_pkg::SUM_W]) ? '1
                                                             : s1_reg[asc_pkg::SUM_W-1:0];
            perfect_reg  <= (n_reg != '0) && (s1_reg == ACC_W'(n_reg));
            amicable_reg <= cmd.amic_check && (sum_reg == ACC_W'(n_reg));
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_count    = count_reg;
    assign out_sum      = osum_reg;
    assign out_perfect  = perfect_reg;
    assign out_amicable = amicable_reg;

endmodule

FILE: design/asc_ctrl.sv
module asc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  asc_pkg::sts_t sts,
    output asc_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INIT = 7'b0000010,
        S_TEST = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_END  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   pass2_reg, pass2_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pass2_next = pass2_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pass2_next = 1'b0;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_pass = 1'b1;
                state_next    = S_TEST;
            end
            S_TEST:
            begin
                if (sts.loop_end)
                begin
                    state_next = S_END;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = S_TEST;
            end
            S_END:
            begin
                if (pass2_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.save_first = 1'b1;
                    if (sts.amic_try)
                    begin
                        pass2_next = 1'b1;
                        state_next = S_INIT;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.amic_check = pass2_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass2_reg <= pass2_next;
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a waiting result");

    a_acc_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accumulate |-> $past(sts.div_done))
        else $error("accumulate without a finished division");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [asc_pkg::COUNT_W-1:0] divisor_count;
        logic [asc_pkg::SUM_W-1:0]   divisor_sum;
        logic                        is_perfect;
        logic                        is_amicable;
    } divisor_report_t;

    localparam longint unsigned COUNT_SAT = (64'd1 << asc_pkg::COUNT_W) - 1;
    localparam longint unsigned SUM_SAT   = (64'd1 << asc_pkg::SUM_W) - 1;
    localparam int NOTABLE_COUNT = 24;
    localparam logic [15:0] NOTABLE [NOTABLE_COUNT] = '{
        16'd220, 16'd284, 16'd1184, 16'd1210, 16'd2620, 16'd2924, 16'd5020, 16'd5564,
        16'd6232, 16'd6368, 16'd10744, 16'd10856, 16'd12285, 16'd14595, 16'd17296,
        16'd18416, 16'd63020, 16'd6, 16'd28, 16'd496, 16'd8128, 16'd0, 16'd1, 16'd2
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [asc_pkg::LIMIT_W-1:0] cfg_wdata;

    asc_in_if  in_ch ();
    asc_out_if out_ch ();

    aliquot_sum_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    divisor_report_t expected_reports [$];
    divisor_report_t oldest_report;
    logic [asc_pkg::LIMIT_W-1:0] limit_model;
    int send_idle_pct;
    int recv_idle_pct;
    int failures;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void scan_divisors(input longint unsigned value,
                                          output longint unsigned total,
                                          output longint unsigned count);
        longint unsigned d;
        longint unsigned q;
        total = 0;
        count = 0;
        if (value >= 2)
        begin
            for (d = 1; d * d <= value; d++)
            begin
                if (value % d == 0)
                begin
                    q = value / d;
                    total += d;
                    count++;
                    if (q != d && q != value)
                    begin
                        total += q;
                        count++;
                    end
                end
            end
        end
    endfunction

    function automatic divisor_report_t classify_number(input logic [15:0] value);
        divisor_report_t r;
        longint unsigned n;
        longint unsigned s;
        longint unsigned c;
        longint unsigned s2;
        longint unsigned c2;
        n = value;
        scan_divisors(n, s, c);
        r.divisor_count = (c > COUNT_SAT) ? COUNT_SAT[asc_pkg::COUNT_W-1:0]
                                          : c[asc_pkg::COUNT_W-1:0];
        r.divisor_sum   = (s > SUM_SAT) ? SUM_SAT[asc_pkg::SUM_W-1:0]
                                        : s[asc_pkg::SUM_W-1:0];
        r.is_perfect    = (n != 0) && (s == n);
        r.is_amicable   = 1'b0;
        if (n < s && s <= limit_model)
        begin
            scan_divisors(s, s2, c2);
            r.is_amicable = (s2 == n);
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result with nothing pending: divisor_count %0d divisor_sum %0d",
                       out_ch.divisor_count, out_ch.divisor_sum);
                failures++;
            end
            else
            begin
                oldest_report = expected_reports.pop_front();
                if (out_ch.divisor_count !== oldest_report.divisor_count)
                begin
                    $error("divisor_count expected %0d actual %0d",
                           oldest_report.divisor_count, out_ch.divisor_count);
                    failures++;
                end
                if (out_ch.divisor_sum !== oldest_report.divisor_sum)
                begin
                    $error("divisor_sum expected %0d actual %0d",
                           oldest_report.divisor_sum, out_ch.divisor_sum);
                    failures++;
                end
                if (out_ch.is_perfect !== oldest_report.is_perfect)
                begin
                    $error("is_perfect expected %0b actual %0b",
                           oldest_report.is_perfect, out_ch.is_perfect);
                    failures++;
                end
                if (out_ch.is_amicable !== oldest_report.is_amicable)
                begin
                    $error("is_amicable expected %0b actual %0b",
                           oldest_report.is_amicable, out_ch.is_amicable);
                    failures++;
                end
            end
        end
    end

    // Called at a falling edge; leaves valid high so back-to-back requests need no gap.
    task automatic send_number(input logic [15:0] value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid  <= 1'b1;
        in_ch.number <= value;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        expected_reports.push_back(classify_number(value));
        @(negedge clk);
    endtask

    task automatic drain_requests();
        in_ch.valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [asc_pkg::LIMIT_W-1:0] value);
        drain_requests();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        limit_model = value;
    endtask

    function automatic logic [15:0] pick_number();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 30)
            return NOTABLE[$urandom_range(NOTABLE_COUNT - 1)];
        else if (sel < 75)
            return 16'($urandom_range(4095));
        else if (sel < 85)
            return 16'($urandom_range(65535, 60000));
        else
            return 16'($urandom);
    endfunction

    task automatic test_reset_limit();
        send_number(16'd0);
        send_number(16'd1);
        send_number(16'd2);
        send_number(16'd3);
        send_number(16'd6);
        send_number(16'd28);
        send_number(16'd496);
        send_number(16'd8128);
        send_number(16'd220);
        send_number(16'd284);
        send_number(16'd1184);
        send_number(16'd1210);
        send_number(16'd12285);
        send_number(16'd55440);
        send_number(16'd63020);
        send_number(16'd65521);
        send_number(16'd32768);
        send_number(16'd65534);
        send_number(16'd65535);
    endtask

    task automatic test_limit_edges();
        write_limit(16'd284);
        send_number(16'd220);
        write_limit(16'd283);
        send_number(16'd220);
        write_limit(16'd2);
        send_number(16'd220);
        send_number(16'd6);
        write_limit(16'hFFFF);
        send_number(16'd1184);
    endtask

    task automatic test_random_numbers(input int items,
                                       input logic [asc_pkg::LIMIT_W-1:0] limit);
        write_limit(limit);
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(11) == 0)
                drain_requests();
            send_number(pick_number());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.number  = '0;
        failures      = 0;
        limit_model   = asc_pkg::LIMIT_RESET;
        send_idle_pct = 11;
        recv_idle_pct = 77;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_limit();
        test_limit_edges();
        test_random_numbers(25, 16'hFFFF);

        send_idle_pct = 77;
        recv_idle_pct = 11;
        test_random_numbers(25, 16'($urandom_range(65535, 2)));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_numbers(25, 16'($urandom_range(20000, 2)));

        drain_requests();
        repeat (20) @(negedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
